@@ rtl/mbd_pkg.sv @@
// Package for the marker-bit byte deframer.
// Frame phase codes, the state record and the result record.
// No dependencies.
`default_nettype none

package mbd_pkg;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_GROUPS = 2'd1,
        PH_DATA   = 2'd2,
        PH_CLOSE  = 2'd3
    } phase_t;

    localparam logic [2:0] CLOSE_AWAIT = 3'd0;
    localparam logic [2:0] CLOSE_SKIP  = 3'd1;
    localparam logic [7:0] END_BYTE    = 8'h08;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] pos;
        logic [6:0] held;
    } dfr_state_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] decoded_byte;
        logic       byte_valid;
        logic       frame_done;
        logic [1:0] frame_status;
    } dfr_result_t;

endpackage

`default_nettype wire

@@ rtl/mbd_step.sv @@
// Per-item decode step: next frame state and result for one encoded byte.
// Purely combinational; uses mbd_pkg.
`default_nettype none

module mbd_step (
    input  wire mbd_pkg::dfr_state_t  state,
    input  wire logic [7:0]           encoded_byte,
    input  wire logic                 input_last,
    output mbd_pkg::dfr_state_t       state_next,
    output mbd_pkg::dfr_result_t      result
);
    import mbd_pkg::*;

    logic [2:0]  p;
    logic [15:0] joined;
    logic [3:0]  rsh;
    logic [7:0]  dec;
    logic        valid;
    logic        done;
    logic [1:0]  status;
    logic        marker;
    logic        pad_bad;
    dfr_state_t  nx;

    always_comb
    begin
        state_next = state;
        nx         = state;
        dec        = 8'd0;
        valid      = 1'b0;
        done       = 1'b0;
        status     = ST_OK;
        p          = (state.phase == PH_GROUPS) ? state.pos : 3'd0;
        joined     = {1'b0, state.held, encoded_byte};
        rsh        = 4'd8 - {1'b0, p};
        marker     = encoded_byte[3'd7 - p];
        pad_bad    = |(encoded_byte & (8'hff >> p));
        result     = '0;

        if (state.phase == PH_CLOSE && state.pos != CLOSE_AWAIT)
        begin
            // skipping to the end of the input frame
            if (input_last)
            begin
                state_next = '{phase: PH_START, pos: 3'd0, held: 7'd0};
            end
        end
        else
        begin
            unique case (state.phase)
                PH_START, PH_GROUPS:
                begin
                    if (state.phase == PH_START && encoded_byte == END_BYTE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (p != 3'd0)
                        begin
                            dec   = 8'(joined >> rsh);
                            valid = 1'b1;
                        end
                        if (marker)
                        begin
                            if (p != 3'd7)
                            begin
                                nx.held  = 7'(encoded_byte & (8'h7f >> p));
                                nx.pos   = p + 3'd1;
                                nx.phase = PH_GROUPS;
                            end
                            else
                            begin
                                nx.held  = 7'd0;
                                nx.pos   = 3'd0;
                                nx.phase = PH_DATA;
                            end
                        end
                        else if (pad_bad)
                        begin
                            done   = 1'b1;
                            status = ST_INVALID;
                        end
                        else
                        begin
                            nx.held  = 7'd0;
                            nx.pos   = CLOSE_AWAIT;
                            nx.phase = PH_CLOSE;
                        end
                    end
                end
                PH_DATA:
                begin
                    dec      = encoded_byte;
                    valid    = 1'b1;
                    nx.held  = 7'd0;
                    nx.pos   = 3'd0;
                    nx.phase = PH_GROUPS;
                end
                PH_CLOSE:
                begin
                    done   = 1'b1;
                    status = (encoded_byte == END_BYTE) ? ST_OK : ST_UNSUPPORTED;
                end
                default:
                begin
                    done = 1'b0;
                end
            endcase

            if (!done && input_last)
            begin
                done   = 1'b1;
                status = ST_INVALID;
            end
            if (done)
            begin
                nx.held = 7'd0;
                if (input_last)
                begin
                    nx.phase = PH_START;
                    nx.pos   = 3'd0;
                end
                else
                begin
                    nx.phase = PH_CLOSE;
                    nx.pos   = CLOSE_SKIP;
                end
            end
            state_next = nx;
            result     = '{emit: valid | done, decoded_byte: dec, byte_valid: valid,
                           frame_done: done, frame_status: status};
        end
    end

endmodule

`default_nettype wire

@@ rtl/marker_bit_byte_deframer_core.sv @@
// Top level of the marker-bit byte deframer: input register, decode step,
// result register and frame state. Uses mbd_pkg and mbd_step.
//
//  channel | direction | tdata           | tuser                           | tlast
//  s_*     | in        | encoded_byte    | -                               | input_last
//  m_*     | out       | decoded_byte    | byte_valid, frame_status[1:0]   | frame_done
//
// One item per cycle unless stalled; each item passes the input register, then the
// decode step into the result register, which also updates the frame state.
// Items that give no result are consumed without reaching the output.
// rst_n clears all valid flags and returns the frame state to frame start.
// A stalled output holds its item; an empty input register still takes one item
// while the held one waits, then s_tready drops until the output moves.
`default_nettype none

module marker_bit_byte_deframer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] encoded_byte
    input  wire logic       s_tlast,   // input_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] decoded_byte
    output logic [2:0]      m_tuser,   // [0] byte_valid, [2:1] frame_status
    output logic            m_tlast    // frame_done
);
    import mbd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    dfr_state_t  state_reg;
    dfr_state_t  state_next;
    dfr_result_t step_res;
    dfr_result_t res_reg;
    logic        res_valid_reg;
    logic        res_free;
    logic        advance;

    assign res_free = !res_valid_reg || m_tready;
    assign advance  = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || res_free;

    mbd_step u_step (
        .state        (state_reg),
        .encoded_byte (in_byte_reg),
        .input_last   (in_last_reg),
        .state_next   (state_next),
        .result       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_START, pos: 3'd0, held: 7'd0};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                res_valid_reg <= step_res.emit;
            end
            else if (m_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg.decoded_byte;
    assign m_tuser  = {res_reg.frame_status, res_reg.byte_valid};
    assign m_tlast  = res_reg.frame_done;

    a_emit_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tlast))
        else $error("result with neither a byte nor a frame end");

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == ST_OK))
        else $error("status reported without frame end");

    a_data_phase_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DATA) |-> (state_reg.pos == 3'd0 && state_reg.held == 7'd0))
        else $error("data phase with pending group bits");

    a_last_resets_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (state_reg.phase == PH_START))
        else $error("frame state not back at start after last item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
